// ===== hw/rtl/cct_pkg.sv =====
// Shared types, constants and rounding helper for the conic coefficient transform.
package cct_pkg;

    // Number formats
    localparam int COEF_W       = 32;
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int ATAN_ENTRIES = 30;
    localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int ZW           = 36;   // angle accumulator, radians at scale 2^30
    localparam int XYW          = 33;   // CORDIC vector, scale 2^30
    localparam int SUM_W        = 100;  // exact wide sums before rounding

    // Trig constants at scale 2^30
    localparam logic signed [XYW-1:0] TRIG_GAIN   = 33'sd652032874;
    localparam logic signed [ZW-1:0]  HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ZW-1:0]  PI_Q30      = 36'sd3373259426;

    // floor(atan(2^-i) * 2^30)
    localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158,
        36'sd67021686,  36'sd33543515,  36'sd16775850,  36'sd8388437,
        36'sd4194282,   36'sd2097149,   36'sd1048575,   36'sd524287,
        36'sd262143,    36'sd131071,    36'sd65535,     36'sd32767,
        36'sd16383,     36'sd8191,      36'sd4095,      36'sd2047,
        36'sd1023,      36'sd511,       36'sd255,       36'sd127,
        36'sd63,        36'sd31,        36'sd15,        36'sd7,
        36'sd3,         36'sd1
    };

    typedef enum logic {
        OP_ROTATE    = 1'b0,
        OP_TRANSLATE = 1'b1
    } op_t;

    // Rounded and clipped coefficient
    typedef struct packed {
        logic              sat;
        logic [COEF_W-1:0] val;
    } rs_t;

    // Round half up by sh bits, then clip to the signed 32-bit range
    function automatic rs_t round_sat(input logic signed [SUM_W-1:0] v, input int sh);
        logic signed [SUM_W-1:0] t;
        rs_t                     r;
        t = v + $signed(SUM_W'(1) << (sh - 1));
        t = t >>> sh;
        if ((&t[SUM_W-1:COEF_W-1]) || !(|t[SUM_W-1:COEF_W-1])) begin
            r.sat = 1'b0;
            r.val = t[COEF_W-1:0];
        end else begin
            r.sat = 1'b1;
            r.val = t[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/cct_cordic.sv =====
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
module cct_cordic
    import cct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [ZW-1:0]  z_in,
    output logic signed [XYW-1:0] x_out,
    output logic signed [XYW-1:0] y_out
);

    logic signed [XYW-1:0] x_reg [CORDIC_N];
    logic signed [XYW-1:0] y_reg [CORDIC_N];
    logic signed [ZW-1:0]  z_reg [CORDIC_N];

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_step
        logic signed [XYW-1:0] xi, yi, x_next, y_next;
        logic signed [ZW-1:0]  zi, z_next;

        // stage input: start vector or previous stage
        if (i == 0) begin : g_first
            assign xi = TRIG_GAIN;
            assign yi = '0;
            assign zi = z_in;
        end else begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end

        // rotate toward zero residual angle
        always_comb begin
            if (zi >= 0) begin
                x_next = xi - (yi >>> i);
                y_next = yi + (xi >>> i);
                z_next = zi - ATAN_Q30[i];
            end else begin
                x_next = xi + (yi >>> i);
                y_next = yi - (xi >>> i);
                z_next = zi + ATAN_Q30[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    assign x_out = x_reg[CORDIC_N-1];
    assign y_out = y_reg[CORDIC_N-1];

endmodule

// ===== hw/rtl/conic_coefficient_transform.sv =====
// Top level: conic coefficient rotation and translation pipeline.
//
// Takes the six Q16.16 coefficients of A*x^2+B*xy+C*y^2+D*x+E*y+F=0 and returns them
// either re-expressed in a frame turned by angle (tuser op = 0; F passes unchanged) or
// with x, y shifted by shift_x, shift_y (op = 1; A, B, C pass unchanged). Results are
// rounded half up and clipped to 32 bits; the saturated flag reports any clip. The block
// accepts one transaction per cycle while the master side does not stall, and passes each
// one through one input stage, one stage per CORDIC step,
// six multiply and sum stages, and the output register. A stall on the master side
// holds the whole pipeline in place.
module conic_coefficient_transform
    import cct_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // coef_a, coef_b, coef_c, coef_d, coef_e, coef_f, angle, shift_x, shift_y
    input  logic [287:0] s_tdata,
    // op
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_a, new_b, new_c, new_d, new_e, new_f
    output logic [191:0] m_tdata,
    // saturated
    output logic [0:0]   m_tuser
);

    typedef struct packed {
        logic               valid;
        op_t                op;
        logic               flip;
        logic signed [31:0] a, b, c, d, e, f, sx, sy;
    } item_t;

    typedef struct packed {
        item_t              it;
        logic signed [31:0] co, si;
        logic signed [63:0] sxx, sxy, syy, ld, le;
        logic signed [64:0] dt1, dt2, et1, et2;
        logic signed [32:0] cma;
    } p1_t;

    typedef struct packed {
        item_t              it;
        logic signed [63:0] cc_raw, ss_raw, cs_raw, dco, esi, eco, dsi;
        logic signed [32:0] cma;
        logic signed [SUM_W-1:0] dsum, esum;
        logic signed [65:0] lin;
        logic signed [63:0] fa_h, fb_h, fc_h;
        logic signed [64:0] fa_l, fb_l, fc_l;
    } p2_t;

    typedef struct packed {
        item_t              it;
        logic signed [31:0] cc, ss, cs, cs2;
        logic signed [32:0] cma;
        logic signed [65:0] rd, re;
        logic signed [SUM_W-1:0] dsum, esum, ta, tb, tc, tl;
    } p3_t;

    typedef struct packed {
        item_t              it;
        logic signed [31:0] dc;
        logic signed [63:0] pa_cc, pb_cs, pc_ss, pa_ss, pc_cc;
        logic signed [64:0] pcs2;
        logic signed [65:0] rd, re;
        logic signed [SUM_W-1:0] dsum, esum, s1, s2;
    } p4_t;

    typedef struct packed {
        item_t              it;
        logic signed [63:0] pbdc;
        logic signed [64:0] pcs2;
        logic signed [65:0] rd, re;
        logic signed [SUM_W-1:0] ra, rc, dsum, esum, fsum;
    } p5_t;

    typedef struct packed {
        item_t                   it;
        logic signed [SUM_W-1:0] ra, rb, rc, rd, re, dsum, esum, fsum;
    } p6_t;

    logic en;
    item_t in_item;
    logic signed [ZW-1:0] z2, z0_next, z0_reg;
    item_t dly_reg [CORDIC_N+1];
    logic signed [XYW-1:0] cx, cy;
    p1_t p1_next, p1_reg;
    p2_t p2_next, p2_reg;
    p3_t p3_next, p3_reg;
    p4_t p4_next, p4_reg;
    p5_t p5_next, p5_reg;
    p6_t p6_next, p6_reg;
    logic         m_tvalid_reg;
    logic [191:0] m_tdata_reg, m_tdata_next;
    logic [0:0]   m_tuser_reg, m_tuser_next;

    // whole pipeline advances when the output register can move
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // unpack input transaction and fold the angle into a quarter turn
    always_comb begin
        in_item.valid = s_tvalid;
        in_item.op    = op_t'(s_tuser[0]);
        in_item.a     = $signed(s_tdata[31:0]);
        in_item.b     = $signed(s_tdata[63:32]);
        in_item.c     = $signed(s_tdata[95:64]);
        in_item.d     = $signed(s_tdata[127:96]);
        in_item.e     = $signed(s_tdata[159:128]);
        in_item.f     = $signed(s_tdata[191:160]);
        in_item.sx    = $signed(s_tdata[255:224]);
        in_item.sy    = $signed(s_tdata[287:256]);
        z2 = ZW'($signed(s_tdata[223:192])) <<< 1;
        if (z2 > HALF_PI_Q30) begin
            z0_next      = z2 - PI_Q30;
            in_item.flip = 1'b1;
        end else if (z2 < -HALF_PI_Q30) begin
            z0_next      = z2 + PI_Q30;
            in_item.flip = 1'b1;
        end else begin
            z0_next      = z2;
            in_item.flip = 1'b0;
        end
    end

    // payload delay line alongside the CORDIC
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= CORDIC_N; k++) begin
                dly_reg[k].valid <= 1'b0;
            end
        end else if (en) begin
            dly_reg[0] <= in_item;
            for (int k = 1; k <= CORDIC_N; k++) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z0_reg <= z0_next;
        end
    end

    cct_cordic u_cordic (
        .aclk  (aclk),
        .en    (en),
        .z_in  (z0_reg),
        .x_out (cx),
        .y_out (cy)
    );

    // P1: sine/cosine sign fix, translate first products
    always_comb begin
        p1_next.it  = dly_reg[CORDIC_N];
        p1_next.co  = 32'(p1_next.it.flip ? -cx : cx);
        p1_next.si  = 32'(p1_next.it.flip ? -cy : cy);
        p1_next.sxx = 64'(p1_next.it.sx) * 64'(p1_next.it.sx);
        p1_next.sxy = 64'(p1_next.it.sx) * 64'(p1_next.it.sy);
        p1_next.syy = 64'(p1_next.it.sy) * 64'(p1_next.it.sy);
        p1_next.ld  = 64'(p1_next.it.d) * 64'(p1_next.it.sx);
        p1_next.le  = 64'(p1_next.it.e) * 64'(p1_next.it.sy);
        p1_next.dt1 = 65'($signed({p1_next.it.a, 1'b0})) * 65'(p1_next.it.sx);
        p1_next.dt2 = 65'(p1_next.it.b) * 65'(p1_next.it.sy);
        p1_next.et1 = 65'(p1_next.it.b) * 65'(p1_next.it.sx);
        p1_next.et2 = 65'($signed({p1_next.it.c, 1'b0})) * 65'(p1_next.it.sy);
        p1_next.cma = 33'(p1_next.it.c) - 33'(p1_next.it.a);
    end

    // P2: trig squares, rotate linear products, translate partial products
    always_comb begin
        p2_next.it     = p1_reg.it;
        p2_next.cma    = p1_reg.cma;
        p2_next.cc_raw = 64'(p1_reg.co) * 64'(p1_reg.co);
        p2_next.ss_raw = 64'(p1_reg.si) * 64'(p1_reg.si);
        p2_next.cs_raw = 64'(p1_reg.co) * 64'(p1_reg.si);
        p2_next.dco    = 64'(p1_reg.it.d) * 64'(p1_reg.co);
        p2_next.esi    = 64'(p1_reg.it.e) * 64'(p1_reg.si);
        p2_next.eco    = 64'(p1_reg.it.e) * 64'(p1_reg.co);
        p2_next.dsi    = 64'(p1_reg.it.d) * 64'(p1_reg.si);
        p2_next.dsum   = SUM_W'(p1_reg.dt1) + SUM_W'(p1_reg.dt2)
                       + (SUM_W'(p1_reg.it.d) <<< FRAC_BITS);
        p2_next.esum   = SUM_W'(p1_reg.et1) + SUM_W'(p1_reg.et2)
                       + (SUM_W'(p1_reg.it.e) <<< FRAC_BITS);
        p2_next.lin    = 66'(p1_reg.ld) + 66'(p1_reg.le);
        p2_next.fa_h   = 64'(p1_reg.it.a) * 64'($signed(p1_reg.sxx[63:32]));
        p2_next.fb_h   = 64'(p1_reg.it.b) * 64'($signed(p1_reg.sxy[63:32]));
        p2_next.fc_h   = 64'(p1_reg.it.c) * 64'($signed(p1_reg.syy[63:32]));
        p2_next.fa_l   = 65'(p1_reg.it.a) * 65'($signed({1'b0, p1_reg.sxx[31:0]}));
        p2_next.fb_l   = 65'(p1_reg.it.b) * 65'($signed({1'b0, p1_reg.sxy[31:0]}));
        p2_next.fc_l   = 65'(p1_reg.it.c) * 65'($signed({1'b0, p1_reg.syy[31:0]}));
    end

    // P3: round trig terms to 2^29, rotate D/E sums, recombine partials
    always_comb begin
        p3_next.it   = p2_reg.it;
        p3_next.cma  = p2_reg.cma;
        p3_next.cc   = 32'((p2_reg.cc_raw + (64'sd1 <<< 30)) >>> 31);
        p3_next.ss   = 32'((p2_reg.ss_raw + (64'sd1 <<< 30)) >>> 31);
        p3_next.cs   = 32'((p2_reg.cs_raw + (64'sd1 <<< 30)) >>> 31);
        p3_next.cs2  = 32'((p2_reg.cs_raw + (64'sd1 <<< 29)) >>> 30);
        p3_next.rd   = 66'(p2_reg.dco) + 66'(p2_reg.esi);
        p3_next.re   = 66'(p2_reg.eco) - 66'(p2_reg.dsi);
        p3_next.dsum = p2_reg.dsum;
        p3_next.esum = p2_reg.esum;
        p3_next.ta   = (SUM_W'(p2_reg.fa_h) <<< 32) + SUM_W'(p2_reg.fa_l);
        p3_next.tb   = (SUM_W'(p2_reg.fb_h) <<< 32) + SUM_W'(p2_reg.fb_l);
        p3_next.tc   = (SUM_W'(p2_reg.fc_h) <<< 32) + SUM_W'(p2_reg.fc_l);
        p3_next.tl   = (SUM_W'(p2_reg.lin) <<< FRAC_BITS)
                     + (SUM_W'(p2_reg.it.f) <<< (2 * FRAC_BITS));
    end

    // P4: rotate quadratic products
    always_comb begin
        p4_next.it    = p3_reg.it;
        p4_next.dc    = p3_reg.cc - p3_reg.ss;
        p4_next.pa_cc = 64'(p3_reg.it.a) * 64'(p3_reg.cc);
        p4_next.pb_cs = 64'(p3_reg.it.b) * 64'(p3_reg.cs);
        p4_next.pc_ss = 64'(p3_reg.it.c) * 64'(p3_reg.ss);
        p4_next.pa_ss = 64'(p3_reg.it.a) * 64'(p3_reg.ss);
        p4_next.pc_cc = 64'(p3_reg.it.c) * 64'(p3_reg.cc);
        p4_next.pcs2  = 65'(p3_reg.cma) * 65'(p3_reg.cs2);
        p4_next.rd    = p3_reg.rd;
        p4_next.re    = p3_reg.re;
        p4_next.dsum  = p3_reg.dsum;
        p4_next.esum  = p3_reg.esum;
        p4_next.s1    = p3_reg.ta + p3_reg.tb;
        p4_next.s2    = p3_reg.tc + p3_reg.tl;
    end

    // P5: B times cos difference, A'/C' sums, F' total
    always_comb begin
        p5_next.it   = p4_reg.it;
        p5_next.pbdc = 64'(p4_reg.it.b) * 64'(p4_reg.dc);
        p5_next.pcs2 = p4_reg.pcs2;
        p5_next.ra   = SUM_W'(p4_reg.pa_cc) + SUM_W'(p4_reg.pb_cs) + SUM_W'(p4_reg.pc_ss);
        p5_next.rc   = SUM_W'(p4_reg.pa_ss) - SUM_W'(p4_reg.pb_cs) + SUM_W'(p4_reg.pc_cc);
        p5_next.rd   = p4_reg.rd;
        p5_next.re   = p4_reg.re;
        p5_next.dsum = p4_reg.dsum;
        p5_next.esum = p4_reg.esum;
        p5_next.fsum = p4_reg.s1 + p4_reg.s2;
    end

    // P6: B' sum, align all sums
    always_comb begin
        p6_next.it   = p5_reg.it;
        p6_next.ra   = p5_reg.ra;
        p6_next.rb   = SUM_W'(p5_reg.pcs2) + SUM_W'(p5_reg.pbdc);
        p6_next.rc   = p5_reg.rc;
        p6_next.rd   = SUM_W'(p5_reg.rd);
        p6_next.re   = SUM_W'(p5_reg.re);
        p6_next.dsum = p5_reg.dsum;
        p6_next.esum = p5_reg.esum;
        p6_next.fsum = p5_reg.fsum;
    end

    // output: round, clip and pick per operation
    always_comb begin
        rs_t ra, rb, rc, rd, re, td, te, tf;
        ra = round_sat(p6_reg.ra, 29);
        rb = round_sat(p6_reg.rb, 29);
        rc = round_sat(p6_reg.rc, 29);
        rd = round_sat(p6_reg.rd, 30);
        re = round_sat(p6_reg.re, 30);
        td = round_sat(p6_reg.dsum, FRAC_BITS);
        te = round_sat(p6_reg.esum, FRAC_BITS);
        tf = round_sat(p6_reg.fsum, 2 * FRAC_BITS);
        unique case (p6_reg.it.op)
            OP_ROTATE: begin
                m_tdata_next = {p6_reg.it.f, re.val, rd.val, rc.val, rb.val, ra.val};
                m_tuser_next = ra.sat | rb.sat | rc.sat | rd.sat | re.sat;
            end
            OP_TRANSLATE: begin
                m_tdata_next = {tf.val, te.val, td.val, p6_reg.it.c, p6_reg.it.b, p6_reg.it.a};
                m_tuser_next = td.sat | te.sat | tf.sat;
            end
            default: begin
                m_tdata_next = '0;
                m_tuser_next = '0;
            end
        endcase
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg.it.valid <= 1'b0;
            p2_reg.it.valid <= 1'b0;
            p3_reg.it.valid <= 1'b0;
            p4_reg.it.valid <= 1'b0;
            p5_reg.it.valid <= 1'b0;
            p6_reg.it.valid <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else if (en) begin
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            p3_reg       <= p3_next;
            p4_reg       <= p4_next;
            p5_reg       <= p5_next;
            p6_reg       <= p6_next;
            m_tvalid_reg <= p6_reg.it.valid;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
